// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Default sample width (Q2.14 at 16 bits).
  localparam int unsigned RMQ_DATA_WIDTH = 16;

  // Number of components that are formed by a division.
  localparam int unsigned NUM_LANES = 3;

  // Which component is taken directly from the root.
  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;

endpackage

// File: rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, with a tag that
// travels alongside each item.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int unsigned W     = 16,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*W-1:0]   rad_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [W-1:0]     root_o,
  output logic [TAG_W-1:0] tag_o
);

  logic             vld_q  [W];
  logic [W-1:0]     rem_q  [W];
  logic [W-1:0]     root_q [W];
  logic [2*W-1:0]   rad_q  [W];
  logic [TAG_W-1:0] tag_q  [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic             vin;
    logic [W-1:0]     rem_in;
    logic [W-1:0]     root_in;
    logic [2*W-1:0]   rad_in;
    logic [TAG_W-1:0] tag_in;
    logic [W+1:0]     cur;
    logic [W+1:0]     trial;
    logic [W+1:0]     rem_nx;
    logic             ge;

    if (s == 0) begin : g_first
      assign vin     = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vin     = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    // Bring down the next two radicand bits and try 4*root + 1.
    assign cur    = {rem_in, rad_in[2*W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (cur >= trial);
    assign rem_nx = ge ? (cur - trial) : cur;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_nx[W-1:0];
        root_q[s] <= {root_in[W-2:0], ge};
        rad_q[s]  <= {rad_in[2*W-3:0], 2'b00};
        tag_q[s]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign root_o  = root_q[W-1];
  assign tag_o   = tag_q[W-1];

endmodule

// File: rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined divider: round(num * 2^(F-1) / q) with halves away
// from zero, saturated to the signed sample range. One quotient bit a stage.
// ----------------------------------------------------------------------------
module rmq_div
  import rmq_pkg::*;
#(
  parameter int unsigned W     = 16,
  parameter int unsigned TAG_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [W-1:0]       q_i,
  input  logic signed [W:0]  num_i [NUM_LANES],
  input  logic [TAG_W-1:0]   tag_i,
  output logic               valid_o,
  output logic signed [W-1:0] quo_o [NUM_LANES],
  output logic [TAG_W-1:0]   tag_o
);

  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

  // Entry stage: magnitude, scaled dividend with the rounding term.
  logic             vld0_q;
  logic [W-1:0]     q0_q;
  logic [TAG_W-1:0] tag0_q;
  logic [2*W-2:0]   dvd0_q [NUM_LANES];
  logic             neg0_q [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_entry
    logic         neg;
    logic [W:0]   mag;
    logic [2*W-2:0] dvd;
    assign neg = num_i[l][W];
    assign mag = neg ? (W+1)'(-num_i[l]) : num_i[l];
    assign dvd = {1'b0, mag, {(W-3){1'b0}}} + (2*W-1)'(q_i[W-1:1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd0_q[l] <= dvd;
        neg0_q[l] <= neg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q   <= q_i;
      tag0_q <= tag_i;
    end
  end

  // Restoring stages.
  logic             vld_q [W];
  logic [W-1:0]     q_q   [W];
  logic [TAG_W-1:0] tag_q [W];
  logic [W-1:0]     rem_q  [W][NUM_LANES];
  logic [W-1:0]     quo_q  [W][NUM_LANES];
  logic [W-1:0]     low_q  [W][NUM_LANES];
  logic             over_q [W][NUM_LANES];
  logic             neg_q  [W][NUM_LANES];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic             vin;
    logic [W-1:0]     qin;
    logic [TAG_W-1:0] tag_in;

    if (s == 0) begin : g_first_ctl
      assign vin    = vld0_q;
      assign qin    = q0_q;
      assign tag_in = tag0_q;
    end else begin : g_next_ctl
      assign vin    = vld_q[s-1];
      assign qin    = q_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[s]   <= qin;
        tag_q[s] <= tag_in;
      end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [W-1:0] rem_in;
      logic [W-1:0] quo_in;
      logic [W-1:0] low_in;
      logic         over_in;
      logic         neg_in;
      logic [W:0]   cur;
      logic [W:0]   diff;
      logic         ge;

      if (s == 0) begin : g_first
        // A quotient of 2^W or more saturates in any case.
        assign rem_in  = {1'b0, dvd0_q[l][2*W-2:W]};
        assign quo_in  = '0;
        assign low_in  = dvd0_q[l][W-1:0];
        assign over_in = ({1'b0, dvd0_q[l][2*W-2:W]} >= q0_q);
        assign neg_in  = neg0_q[l];
      end else begin : g_next
        assign rem_in  = rem_q[s-1][l];
        assign quo_in  = quo_q[s-1][l];
        assign low_in  = low_q[s-1][l];
        assign over_in = over_q[s-1][l];
        assign neg_in  = neg_q[s-1][l];
      end

      assign cur  = {rem_in, low_in[W-1]};
      assign ge   = (cur >= {1'b0, qin});
      assign diff = cur - {1'b0, qin};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][l]  <= ge ? diff[W-1:0] : cur[W-1:0];
          quo_q[s][l]  <= {quo_in[W-2:0], ge};
          low_q[s][l]  <= {low_in[W-2:0], 1'b0};
          over_q[s][l] <= over_in;
          neg_q[s][l]  <= neg_in;
        end
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_sat
    logic [W-1:0] mag;
    logic         big;
    assign mag = quo_q[W-1][l];
    assign big = over_q[W-1][l] | mag[W-1];
    always_comb begin
      if (neg_q[W-1][l]) begin
        quo_o[l] = big ? NEG_MIN : W'(-mag);
      end else begin
        quo_o[l] = big ? POS_MAX : mag;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign tag_o   = tag_q[W-1];

endmodule

// File: rtl/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Rotation matrix (three basis vectors, Q2.F) to quaternion by the trace
// method, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                    Handshake
//  s_axis    in   tdata: 9 matrix entries, xcol_x lowest      tvalid/tready
//  m_axis    out  tdata: quat_w,x,y,z; tuser: invalid         tvalid/tready
//
//  The path is one setup stage, a DATA_WIDTH-stage square root, a
//  DATA_WIDTH+1-stage divider and the output register. One item enters
//  every cycle while the output is not stalled.
//  Reset clears all valid bits; no item is in flight after reset.
//  A stalled output holds the whole pipeline; items already inside wait.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = RMQ_DATA_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // xcol_x, xcol_y, xcol_z, ycol_x, ycol_y, ycol_z, zcol_x, zcol_y, zcol_z
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // invalid
  output logic [0:0] m_axis_tuser
);

  localparam int unsigned W       = DATA_WIDTH;
  localparam int unsigned F       = W - 2;
  localparam int unsigned OUT_W   = ((4*W+7)/8)*8;
  localparam int unsigned STAG_W  = 3 + NUM_LANES*(W+1);
  localparam int unsigned DTAG_W  = 3 + W;
  localparam logic signed [W+2:0] ONE_E = {4'b0000, 1'b1, {F{1'b0}}};
  localparam logic [W-1:0]        ONE_W = {2'b01, {F{1'b0}}};
  localparam logic [W-1:0]        POS_MAX = {1'b0, {(W-1){1'b1}}};

  logic en;
  logic out_vld_q;

  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  // Setup stage: trace, branch choice, root argument and numerators.
  logic signed [W+2:0] m [9];
  for (genvar k = 0; k < 9; k++) begin : g_unpack
    assign m[k] = {{3{s_axis_tdata[k*W+W-1]}}, s_axis_tdata[k*W +: W]};
  end

  logic signed [W+2:0] tr;
  logic signed [W+2:0] arg;
  logic [1:0]          sel;
  logic signed [W+2:0] n_e [NUM_LANES];
  logic                inv;

  // m11=m[0] m21=m[1] m31=m[2] m12=m[3] m22=m[4] m32=m[5] m13=m[6] m23=m[7]
  // m33=m[8]
  assign tr = m[0] + m[4] + m[8];

  always_comb begin
    if (tr > 0) begin
      sel = SEL_TRACE;
      arg = tr + ONE_E;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      sel = SEL_X;
      arg = ONE_E + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      sel = SEL_Y;
      arg = ONE_E + m[4] - m[0] - m[8];
    end else begin
      sel = SEL_Z;
      arg = ONE_E + m[8] - m[0] - m[4];
    end
  end

  always_comb begin
    case (sel)
      SEL_TRACE: begin
        n_e[0] = m[5] - m[7];
        n_e[1] = m[6] - m[2];
        n_e[2] = m[1] - m[3];
      end
      SEL_X: begin
        n_e[0] = m[5] - m[7];
        n_e[1] = m[3] + m[1];
        n_e[2] = m[6] + m[2];
      end
      SEL_Y: begin
        n_e[0] = m[6] - m[2];
        n_e[1] = m[3] + m[1];
        n_e[2] = m[7] + m[5];
      end
      default: begin
        n_e[0] = m[1] - m[3];
        n_e[1] = m[6] + m[2];
        n_e[2] = m[7] + m[5];
      end
    endcase
  end

  assign inv = (arg <= 0);

  logic                a_vld_q;
  logic [2*W-1:0]      a_rad_q;
  logic [STAG_W-1:0]   a_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_rad_q <= inv ? '0 : {1'b0, arg[W:0], {F{1'b0}}};
      a_tag_q <= {n_e[2][W:0], n_e[1][W:0], n_e[0][W:0], inv, sel};
    end
  end

  // Square root.
  logic              r_vld;
  logic [W-1:0]      r_root;
  logic [STAG_W-1:0] r_tag;

  rmq_sqrt #(
    .W     (W),
    .TAG_W (STAG_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_vld_q),
    .rad_i   (a_rad_q),
    .tag_i   (a_tag_q),
    .valid_o (r_vld),
    .root_o  (r_root),
    .tag_o   (r_tag)
  );

  logic [W-1:0]     q_fix;
  logic [W:0]       q_inc;
  logic signed [W:0] r_num [NUM_LANES];
  logic [DTAG_W-1:0] d_tag_in;

  assign q_fix = (r_root == '0) ? W'(1) : r_root;
  assign q_inc = {1'b0, q_fix} + (W+1)'(1);
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_num
    assign r_num[l] = r_tag[3 + l*(W+1) +: (W+1)];
  end
  assign d_tag_in = {q_inc[W:1], r_tag[2:0]};

  // Division.
  logic               d_vld;
  logic signed [W-1:0] d_quo [NUM_LANES];
  logic [DTAG_W-1:0]  d_tag;

  rmq_div #(
    .W     (W),
    .TAG_W (DTAG_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_vld),
    .q_i     (q_fix),
    .num_i   (r_num),
    .tag_i   (d_tag_in),
    .valid_o (d_vld),
    .quo_o   (d_quo),
    .tag_o   (d_tag)
  );

  // Output assembly.
  logic [1:0]   o_sel;
  logic         o_inv;
  logic [W-1:0] o_half;
  logic [W-1:0] half_sat;
  logic [W-1:0] qw, qx, qy, qz;

  assign o_sel    = d_tag[1:0];
  assign o_inv    = d_tag[2];
  assign o_half   = d_tag[DTAG_W-1:3];
  assign half_sat = o_half[W-1] ? POS_MAX : o_half;

  always_comb begin
    if (o_inv) begin
      qw = ONE_W;
      qx = '0;
      qy = '0;
      qz = '0;
    end else begin
      case (o_sel)
        SEL_TRACE: begin
          qw = half_sat; qx = d_quo[0]; qy = d_quo[1]; qz = d_quo[2];
        end
        SEL_X: begin
          qw = d_quo[0]; qx = half_sat; qy = d_quo[1]; qz = d_quo[2];
        end
        SEL_Y: begin
          qw = d_quo[0]; qx = d_quo[1]; qy = half_sat; qz = d_quo[2];
        end
        default: begin
          qw = d_quo[0]; qx = d_quo[1]; qy = d_quo[2]; qz = half_sat;
        end
      endcase
    end
  end

  logic [OUT_W-1:0] out_data_q;
  logic             out_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= OUT_W'({qz, qy, qx, qw});
      out_inv_q  <= o_inv;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_inv_q;

endmodule

// File: rtl/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
module rmq_checker
  import rmq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = RMQ_DATA_WIDTH
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic [0:0] m_axis_tuser
);

  localparam logic [DATA_WIDTH-1:0] ONE_W = (DATA_WIDTH)'(1) << (DATA_WIDTH-2);

  // A waiting result is neither dropped nor changed.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // With the output register empty the pipeline must take input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An invalid result carries the identity quaternion.
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[DATA_WIDTH-1:0] == ONE_W &&
      m_axis_tdata[4*DATA_WIDTH-1:DATA_WIDTH] == '0)
    else $error("invalid result is not the identity");

  // No result appears in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result item present right after reset");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (.*);
